// ===== src/halc_pkg.sv =====
package halc_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int MAX_ADDR_IDS = 8;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int CNT_W        = 5;
   localparam int LEN_W        = 4;
   localparam int IDS_W        = 64;
   localparam int STAMP_W      = 64;

   localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT       = CNT_W'(TABLE_DEPTH);
   localparam logic [LEN_W-1:0] MAX_LEN         = LEN_W'(MAX_ADDR_IDS);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CHECK  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD
   } state_type;

   // query travelling down the cell chain
   typedef struct packed {
      logic             valid;
      logic [IDS_W-1:0] ids;
      logic [LEN_W-1:0] qlen;
      logic [CNT_W-1:0] cnt;
      logic [LEN_W-1:0] best;
   } token_type;

   // entry write broadcast to all cells
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [IDS_W-1:0] ids;
      logic [LEN_W-1:0] len;
   } write_type;

   // keep the low n ID bytes
   function automatic logic [IDS_W-1:0] bytes_mask(input logic [LEN_W-1:0] n);
      logic [IDS_W-1:0] m;
      m = '0;
      for (int b = 0; b < IDS_W / 8; b++) begin
         m[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

// ===== src/halc_cell.sv =====
module halc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [halc_pkg::IDX_W-1:0]  cell_idx,
   input  halc_pkg::write_type         wr,
   input  halc_pkg::token_type         tok_in,
   output halc_pkg::token_type         tok_out
);

   logic [halc_pkg::IDS_W-1:0] ids_ff;
   logic [halc_pkg::LEN_W-1:0] len_ff;
   halc_pkg::token_type        tok_ff, tok_in_nx;
   logic                       match;

   // entry must be live, a nonempty proper prefix, and equal to the masked query
   always_comb begin
      match = (halc_pkg::CNT_W'(cell_idx) < tok_in.cnt)
           && (len_ff != '0) && (len_ff < tok_in.qlen)
           && (ids_ff == (tok_in.ids & halc_pkg::bytes_mask(len_ff)));
      tok_in_nx = tok_in;
      if (match && (len_ff > tok_in.best)) begin
         tok_in_nx.best = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_idx)) begin
         ids_ff <= wr.ids;
         len_ff <= wr.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.ids  <= tok_in_nx.ids;
      tok_ff.qlen <= tok_in_nx.qlen;
      tok_ff.cnt  <= tok_in_nx.cnt;
      tok_ff.best <= tok_in_nx.best;
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/hierarchical_address_table_loop_check_core.sv =====
// Add, remove and clear: result in the output register the cycle after the request.
// Loop check: the query walks the row of TABLE_DEPTH entry cells, one cell per
// cycle, then its best length is registered and loaded into the output register.
// One request in flight at a time; a check holds the block until its result loads.
// Synchronous active-high reset: count and table stamp zero, capacity = TABLE_DEPTH,
// no query in the chain, no response pending. Entry contents are not reset.
module hierarchical_address_table_loop_check_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [halc_pkg::IDS_W-1:0]     req_addr_ids,
   input  logic [halc_pkg::LEN_W-1:0]     req_addr_len,
   input  logic [halc_pkg::STAMP_W-1:0]   req_stamp,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic                           rsp_loop_found,
   output logic [halc_pkg::LEN_W-1:0]     rsp_prefix_len,
   output logic [halc_pkg::CNT_W-1:0]     rsp_entry_count,
   // capacity register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [halc_pkg::CNT_W-1:0]     csr_data
);

   halc_pkg::state_type state_ff, state_in;

   // table control state
   logic [halc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [halc_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [halc_pkg::CNT_W-1:0]   max_entries_ff, max_entries_in;
   logic [halc_pkg::LEN_W-1:0]   scan_best_ff, scan_best_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic                         rsp_loop_ff, rsp_loop_in;
   logic [halc_pkg::LEN_W-1:0]   rsp_plen_ff, rsp_plen_in;
   logic [halc_pkg::CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                         req_accept;
   logic                         slot_free;
   logic                         load_scan;
   logic [halc_pkg::LEN_W-1:0]   len_clamped;
   logic [halc_pkg::IDS_W-1:0]   ids_masked;
   logic [halc_pkg::CNT_W-1:0]   capacity;
   logic [halc_pkg::CNT_W-1:0]   cnt_eff;

   halc_pkg::write_type          wr;
   halc_pkg::token_type          tok [halc_pkg::TABLE_DEPTH+1];

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // saturate length, zero the ID bytes past it
   assign len_clamped = (req_addr_len > halc_pkg::MAX_LEN) ? halc_pkg::MAX_LEN : req_addr_len;
   assign ids_masked  = req_addr_ids & halc_pkg::bytes_mask(len_clamped);
   assign capacity    = (max_entries_ff >= halc_pkg::DEPTH_CNT) ? halc_pkg::DEPTH_CNT
                                                                : max_entries_ff;

   // a newer stamp on a nonempty table empties it before the append
   assign cnt_eff = ((count_ff != '0) && (req_stamp > stamp_ff)) ? '0 : count_ff;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         halc_pkg::ST_IDLE: begin
            if (req_accept && (halc_pkg::op_type'(req_operation) == halc_pkg::OP_CHECK)) begin
               state_in = halc_pkg::ST_SCAN;
            end
         end
         halc_pkg::ST_SCAN: begin
            if (tok[halc_pkg::TABLE_DEPTH].valid) begin
               state_in = halc_pkg::ST_LOAD;
            end
         end
         halc_pkg::ST_LOAD: begin
            if (slot_free) begin
               state_in = halc_pkg::ST_IDLE;
            end
         end
         default: state_in = halc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load_scan = 1'b0;
      case (state_ff)
         halc_pkg::ST_IDLE: req_ready = slot_free;
         halc_pkg::ST_LOAD: load_scan = slot_free;
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      count_in       = count_ff;
      stamp_in       = stamp_ff;
      max_entries_in = max_entries_ff;
      scan_best_in   = scan_best_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_loop_in    = rsp_loop_ff;
      rsp_plen_in    = rsp_plen_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      wr.en  = 1'b0;
      wr.idx = cnt_eff[halc_pkg::IDX_W-1:0];
      wr.ids = ids_masked;
      wr.len = len_clamped;

      tok[0].valid = 1'b0;
      tok[0].ids   = ids_masked;
      tok[0].qlen  = len_clamped;
      tok[0].cnt   = count_ff;
      tok[0].best  = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         rsp_loop_in = 1'b0;
         rsp_plen_in = '0;
         case (halc_pkg::op_type'(req_operation))
            halc_pkg::OP_ADD: begin
               if (cnt_eff < capacity) begin
                  wr.en     = 1'b1;
                  count_in  = cnt_eff + 1'b1;
                  rsp_ok_in = 1'b1;
                  if (cnt_eff == '0) begin
                     stamp_in = req_stamp;
                  end
               end else begin
                  count_in  = cnt_eff;
                  rsp_ok_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = count_in;
            end
            halc_pkg::OP_CHECK: begin
               // result comes back from the end of the cell chain
               tok[0].valid = 1'b1;
            end
            halc_pkg::OP_REMOVE: begin
               if (count_ff != '0) begin
                  count_in  = count_ff - 1'b1;
                  rsp_ok_in = 1'b1;
               end else begin
                  rsp_ok_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = count_in;
            end
            halc_pkg::OP_CLEAR: begin
               count_in     = '0;
               rsp_ok_in    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = '0;
            end
            default: ;
         endcase
      end

      if (tok[halc_pkg::TABLE_DEPTH].valid) begin
         scan_best_in = tok[halc_pkg::TABLE_DEPTH].best;
      end

      if (load_scan) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b0;
         rsp_loop_in  = (scan_best_ff != '0);
         rsp_plen_in  = scan_best_ff;
         rsp_cnt_in   = count_ff;
      end

      if (csr_valid && csr_ready) begin
         max_entries_in = csr_data;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= halc_pkg::ST_IDLE;
         count_ff       <= '0;
         stamp_ff       <= '0;
         max_entries_ff <= halc_pkg::MAX_ENTRIES_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         stamp_ff       <= stamp_in;
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      scan_best_ff <= scan_best_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_loop_ff  <= rsp_loop_in;
      rsp_plen_ff  <= rsp_plen_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   // ---------------- entry cell chain ----------------
   // each cell holds one entry and folds its match into the passing query
   for (genvar i = 0; i < halc_pkg::TABLE_DEPTH; i++) begin : g_cell
      halc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_idx(halc_pkg::IDX_W'(i)),
         .wr      (wr),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_loop_found  = rsp_loop_ff;
   assign rsp_prefix_len  = rsp_plen_ff;
   assign rsp_entry_count = rsp_cnt_ff;

endmodule

// ===== src/halc_checker.sv =====
module halc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ok,
   input logic                         rsp_loop_found,
   input logic [halc_pkg::LEN_W-1:0]   rsp_prefix_len,
   input logic [halc_pkg::CNT_W-1:0]   rsp_entry_count
);

   // a pending response is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // loop flag and prefix length agree, and a loop never comes with ok
   a_loop_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_loop_found == (rsp_prefix_len != '0)) && !(rsp_ok && rsp_loop_found)))
      else $error("loop flag inconsistent");

   // a stored proper prefix is shorter than the longest address
   a_plen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prefix_len < halc_pkg::MAX_LEN))
      else $error("prefix length out of range");

   // never more entries than the table holds
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= halc_pkg::DEPTH_CNT))
      else $error("entry count out of range");

   // one request at a time: no request taken while a response is stalled
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("request taken while response stalled");

endmodule

bind hierarchical_address_table_loop_check_core halc_checker u_halc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ok         (rsp_ok),
   .rsp_loop_found (rsp_loop_found),
   .rsp_prefix_len (rsp_prefix_len),
   .rsp_entry_count(rsp_entry_count)
);
